/* sv/endpoint_filter_nth_match_core_assert.svh */
// ---------------------------------------------------------------------------
// Endpoint filter assertion macros
// Shared immediate-style wrappers for concurrent checks on clk / arst_n.
// ---------------------------------------------------------------------------
`ifndef ENDPOINT_FILTER_NTH_MATCH_CORE_ASSERT_SVH
`define ENDPOINT_FILTER_NTH_MATCH_CORE_ASSERT_SVH

// same-cycle implication
`define EFNM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define EFNM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/efnm_pkg.sv */
// ---------------------------------------------------------------------------
// Endpoint filter package
// Shared widths, codes and types for the endpoint lookup chain.
// ---------------------------------------------------------------------------
package efnm_pkg;

	localparam int EP_DEPTH   = 32;
	localparam int SLOT_W     = $clog2(EP_DEPTH);
	localparam int EP_COUNT_W = 6;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;

	localparam logic [1:0] DIR_ANY  = 2'd2;
	localparam logic [4:0] NUM_ANY  = 5'd16;
	localparam logic [2:0] TYPE_ANY = 3'd4;

	localparam logic FUNC_WRITE  = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_EP_COUNT     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CTRL_PRESENT = CFG_IDX_W'(1);

	typedef struct packed {
		logic       present;
		logic [7:0] iface;
		logic       dir;
		logic [3:0] num;
		logic [1:0] xfer;
	} ep_entry_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		ep_entry_t         entry;
	} wr_t;

	// lookup transaction travelling down the cell row
	typedef struct packed {
		logic                  valid;
		logic [7:0]            want_iface;
		logic [1:0]            want_dir;
		logic [4:0]            want_num;
		logic [2:0]            want_type;
		logic [7:0]            count;
		logic [EP_COUNT_W-1:0] limit;
		logic                  seen;
		logic                  hit;
		logic [SLOT_W-1:0]     hit_slot;
	} tok_t;

endpackage

/* sv/efnm_item_if.sv */
// ---------------------------------------------------------------------------
// Endpoint filter item channel
// Valid/ready channel carrying one write or lookup transaction.
// ---------------------------------------------------------------------------
interface efnm_item_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [4:0] slot;
	logic       entry_present;
	logic [7:0] entry_iface;
	logic       entry_dir;
	logic [3:0] entry_num;
	logic [1:0] entry_type;
	logic [7:0] want_iface;
	logic [1:0] want_dir;
	logic [4:0] want_num;
	logic [2:0] want_type;
	logic [7:0] want_nth;

	modport source (
		output valid, func, slot, entry_present, entry_iface, entry_dir, entry_num,
		       entry_type, want_iface, want_dir, want_num, want_type, want_nth,
		input  ready
	);
	modport sink (
		input  valid, func, slot, entry_present, entry_iface, entry_dir, entry_num,
		       entry_type, want_iface, want_dir, want_num, want_type, want_nth,
		output ready
	);
endinterface

/* sv/efnm_result_if.sv */
// ---------------------------------------------------------------------------
// Endpoint filter result channel
// Valid/ready channel carrying one lookup result transaction.
// ---------------------------------------------------------------------------
interface efnm_result_if;
	logic       valid;
	logic       ready;
	logic       found;
	logic       is_control;
	logic [4:0] found_slot;

	modport source (output valid, found, is_control, found_slot, input ready);
	modport sink   (input valid, found, is_control, found_slot, output ready);
endinterface

/* sv/efnm_cfg_if.sv */
// ---------------------------------------------------------------------------
// Endpoint filter configuration channel
// Valid/ready register write channel: register index and write data.
// ---------------------------------------------------------------------------
interface efnm_cfg_if;
	logic       valid;
	logic       ready;
	logic [3:0] index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

/* sv/efnm_cell.sv */
// ---------------------------------------------------------------------------
// Endpoint filter cell
// Holds one table entry; checks the passing lookup against it and forwards it.
// ---------------------------------------------------------------------------
module efnm_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [efnm_pkg::SLOT_W-1:0]  idx,
	input  efnm_pkg::wr_t                wr,
	input  efnm_pkg::tok_t               tok_in,
	output efnm_pkg::tok_t               tok_out
);
	import efnm_pkg::*;

	logic      present_q;
	ep_entry_t entry_q;
	tok_t      tok_nxt;
	tok_t      tok_q;
	logic      active;
	logic      iface_hit;
	logic      pass;
	logic      any_filter;

	always_comb begin
		any_filter = (tok_in.want_dir != DIR_ANY) || (tok_in.want_num != NUM_ANY) ||
		             (tok_in.want_type != TYPE_ANY);
		active     = tok_in.valid && !tok_in.hit && (EP_COUNT_W'(idx) < tok_in.limit);
		iface_hit  = present_q && (entry_q.iface == tok_in.want_iface);
		pass       = ((tok_in.want_dir == DIR_ANY) || ({1'b0, entry_q.dir} == tok_in.want_dir)) &&
		             ((tok_in.want_num == NUM_ANY) || ({1'b0, entry_q.num} == tok_in.want_num)) &&
		             ((tok_in.want_type == TYPE_ANY) ||
		              ({1'b0, entry_q.xfer} == tok_in.want_type));
		tok_nxt    = tok_in;
		if (active && iface_hit) begin
			tok_nxt.seen = 1'b1;
			if (pass) begin
				if (tok_in.count == 8'd0 && any_filter) begin
					tok_nxt.hit      = 1'b1;
					tok_nxt.hit_slot = idx;
				end else begin
					tok_nxt.count = tok_in.count - 8'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
			tok_q     <= '0;
		end else begin
			if (wr.en && wr.slot == idx) begin
				present_q <= wr.entry.present;
			end
			tok_q <= tok_nxt;
		end
	end

	// entry payload, no reset
	always_ff @(posedge clk) begin
		if (wr.en && wr.slot == idx) begin
			entry_q <= wr.entry;
		end
	end

	assign tok_out = tok_q;

endmodule

/* sv/endpoint_filter_nth_match_core.sv */
// ---------------------------------------------------------------------------
// Endpoint filter nth-match core
// Endpoint table with filtered nth-match lookup over a row of entry cells.
// ---------------------------------------------------------------------------
// Write transactions (func = write) land in the addressed cell at the accepting
// edge; they give no result. A lookup transaction enters the head register of
// the row and visits one cell per cycle, then passes the finish stage and, when
// the output register can take it, moves there and is offered on results. Every
// lookup walks all EP_DEPTH (32) cells whatever ep_count is, since the row walk
// is fixed-length. Only one lookup is in the row at a time; items is not ready
// from lookup acceptance until its result has moved into the output register,
// while a finished result waiting on results does not block a new transaction.
// The table powers up with every entry absent; there is no clearing pass.
// ---------------------------------------------------------------------------
module endpoint_filter_nth_match_core (
	input  logic      clk,
	input  logic      arst_n,
	efnm_item_if.sink     items,
	efnm_result_if.source results,
	efnm_cfg_if.sink      cfg
);
	import efnm_pkg::*;

	`include "endpoint_filter_nth_match_core_assert.svh"

	// configuration registers
	logic [EP_COUNT_W-1:0] ep_count_q;
	logic                  ctrl_present_q;
	logic [EP_COUNT_W-1:0] limit;

	// control
	logic busy_q;
	logic item_acc;
	logic cfg_acc;
	wr_t  wr;

	// cell row; tok[0] is the head register, tok[EP_DEPTH] leaves the last cell
	tok_t                tok [EP_DEPTH+1];
	tok_t                head_q;
	logic [EP_DEPTH:0]   tok_valid;

	// finish stage
	logic              fin_valid_q;
	logic              fin_found_q;
	logic              fin_ctrl_q;
	logic [SLOT_W-1:0] fin_slot_q;
	logic              end_any_filter;
	logic              end_ctrl;
	logic              fin_move;

	// output register
	logic              res_valid_q;
	logic              res_found_q;
	logic              res_ctrl_q;
	logic [SLOT_W-1:0] res_slot_q;

	assign items.ready = !busy_q;
	assign item_acc    = items.valid && items.ready;
	assign cfg.ready   = 1'b1;
	assign cfg_acc     = cfg.valid && cfg.ready;

	// ep_count above the table depth searches the whole table
	assign limit = (ep_count_q > EP_COUNT_W'(EP_DEPTH)) ? EP_COUNT_W'(EP_DEPTH) : ep_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ep_count_q     <= '0;
			ctrl_present_q <= 1'b0;
		end else if (cfg_acc) begin
			case (cfg.index)
				REG_EP_COUNT:     ep_count_q     <= cfg.data[EP_COUNT_W-1:0];
				REG_CTRL_PRESENT: ctrl_present_q <= cfg.data[0];
				default:          ;
			endcase
		end
	end

	// write broadcast to the row; each cell matches its own index
	always_comb begin
		wr.en            = item_acc && (items.func == FUNC_WRITE);
		wr.slot          = items.slot;
		wr.entry.present = items.entry_present;
		wr.entry.iface   = items.entry_iface;
		wr.entry.dir     = items.entry_dir;
		wr.entry.num     = items.entry_num;
		wr.entry.xfer    = items.entry_type;
	end

	// head of row: a lookup transaction becomes a token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else begin
			head_q.valid <= item_acc && (items.func == FUNC_LOOKUP);
			if (item_acc) begin
				head_q.want_iface <= items.want_iface;
				head_q.want_dir   <= items.want_dir;
				head_q.want_num   <= items.want_num;
				head_q.want_type  <= items.want_type;
				head_q.count      <= items.want_nth;
				head_q.limit      <= limit;
				head_q.seen       <= 1'b0;
				head_q.hit        <= 1'b0;
				head_q.hit_slot   <= '0;
			end
		end
	end

	assign tok[0] = head_q;

	for (genvar g = 0; g < EP_DEPTH; g++) begin : g_cell
		efnm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (SLOT_W'(g)),
			.wr      (wr),
			.tok_in  (tok[g]),
			.tok_out (tok[g+1])
		);
	end

	for (genvar g = 0; g <= EP_DEPTH; g++) begin : g_vld
		assign tok_valid[g] = tok[g].valid;
	end

	// end of walk: control endpoint fallback
	always_comb begin
		end_any_filter = (tok[EP_DEPTH].want_dir != DIR_ANY) ||
		                 (tok[EP_DEPTH].want_num != NUM_ANY) ||
		                 (tok[EP_DEPTH].want_type != TYPE_ANY);
		end_ctrl       = !tok[EP_DEPTH].hit && ctrl_present_q &&
		                 !(tok[EP_DEPTH].seen && end_any_filter) &&
		                 (tok[EP_DEPTH].count == 8'd0);
	end

	assign fin_move = fin_valid_q && (!res_valid_q || results.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			fin_valid_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (item_acc && items.func == FUNC_LOOKUP) begin
				busy_q <= 1'b1;
			end else if (fin_move) begin
				busy_q <= 1'b0;
			end
			if (tok[EP_DEPTH].valid) begin
				fin_valid_q <= 1'b1;
			end else if (fin_move) begin
				fin_valid_q <= 1'b0;
			end
			if (fin_move) begin
				res_valid_q <= 1'b1;
			end else if (results.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tok[EP_DEPTH].valid) begin
			fin_found_q <= tok[EP_DEPTH].hit || end_ctrl;
			fin_ctrl_q  <= end_ctrl;
			fin_slot_q  <= tok[EP_DEPTH].hit ? tok[EP_DEPTH].hit_slot : '0;
		end
		if (fin_move) begin
			res_found_q <= fin_found_q;
			res_ctrl_q  <= fin_ctrl_q;
			res_slot_q  <= fin_slot_q;
		end
	end

	assign results.valid      = res_valid_q;
	assign results.found      = res_found_q;
	assign results.is_control = res_ctrl_q;
	assign results.found_slot = res_slot_q;

	// at most one lookup in the row and finish stage, and only while busy
	`EFNM_ASSERT_NOW(a_one_token, 1'b1, $countones({tok_valid, fin_valid_q}) <= 1,
		"more than one lookup in flight")
	`EFNM_ASSERT_NOW(a_tok_busy, (tok_valid != '0) || fin_valid_q, busy_q,
		"lookup in flight while not busy")
	`EFNM_ASSERT_NEXT(a_fin_to_out, fin_move, res_valid_q && !fin_valid_q && !busy_q,
		"finish stage did not hand over its result")
	`EFNM_ASSERT_NOW(a_ctrl_form, res_valid_q && res_ctrl_q,
		res_found_q && (res_slot_q == '0), "control result not well formed")

endmodule

/* tb/sv/endpoint_filter_nth_match_core_tb.sv */
// ---------------------------------------------------------------------------
// Endpoint filter nth-match core testbench
// Drives table writes and filtered lookups into the core and checks every
// lookup result against a shadow table walked in the testbench. Registers
// are changed between phases only, once all results are back.
// ---------------------------------------------------------------------------
module endpoint_filter_nth_match_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import efnm_pkg::*;

	// wait long enough for one lookup to pass the whole row plus the finish stage
	localparam int LOOKUP_CYCLES = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int MAX_REPORTS   = 50;

	localparam logic       DIR_OUT      = 1'b0;
	localparam logic       DIR_IN       = 1'b1;
	localparam logic [1:0] DIR_INVALID  = 2'd3;
	localparam logic [4:0] NUM_INVALID  = 5'd17;
	localparam logic [2:0] TYPE_INVALID = 3'd5;

	localparam logic [1:0] XFER_CTRL = 2'd0;
	localparam logic [1:0] XFER_ISO  = 2'd1;
	localparam logic [1:0] XFER_BULK = 2'd2;
	localparam logic [1:0] XFER_INTR = 2'd3;

	// indexes past the two real registers must be ignored by the core
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

	// one item transaction: write fields and lookup fields side by side
	typedef struct packed {
		logic       func;
		logic [4:0] slot;
		ep_entry_t  entry;
		logic [7:0] want_iface;
		logic [1:0] want_dir;
		logic [4:0] want_num;
		logic [2:0] want_type;
		logic [7:0] want_nth;
	} ep_item_t;

	typedef struct packed {
		logic       found;
		logic       is_control;
		logic [4:0] found_slot;
	} ep_match_t;

	logic clk;
	logic arst_n;

	efnm_item_if   item_ch ();
	efnm_result_if res_ch ();
	efnm_cfg_if    cfg_ch ();

	endpoint_filter_nth_match_core u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_ch),
		.results (res_ch),
		.cfg     (cfg_ch)
	);

	// shadow copy of the endpoint table and the two registers
	ep_entry_t             ep_shadow [EP_DEPTH];
	logic [EP_COUNT_W-1:0] shadow_ep_count;
	logic                  shadow_ctrl;

	ep_item_t  pending_items [$];
	ep_match_t expected_matches [$];
	ep_item_t  cur_item;

	// idling controls; the enables and hold_kick are changed by the stimulus process at falling edges only
	bit src_idle_on;
	bit sink_idle_on;
	bit hold_kick;
	int hold_left;
	int src_gap;
	int sink_gap;

	int n_mismatches;
	int n_writes;
	int n_lookups;
	int n_hits;
	int n_ctrl;
	int n_misses;
	int n_cfg_writes;
	int cycle_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Walk the shadow table the way the core walks its row of cells: skip
	// absent entries and other interfaces, filter, then count down want_nth
	// over the survivors. The skip counter wraps at 8 bits.
	function automatic ep_match_t nth_match(ep_item_t req);
		ep_match_t res;
		logic [7:0] skip;
		bit filtered;
		bit seen;
		int span;
		res = '0;
		skip = req.want_nth;
		seen = 1'b0;
		filtered = (req.want_dir != DIR_ANY) || (req.want_num != NUM_ANY) ||
			(req.want_type != TYPE_ANY);
		span = (shadow_ep_count > EP_DEPTH) ? EP_DEPTH : int'(shadow_ep_count);
		for (int i = 0; i < span; i++) begin
			if (!ep_shadow[i].present || ep_shadow[i].iface != req.want_iface)
				continue;
			seen = 1'b1;
			// out-of-range filter codes compare as-is and so never match
			if (req.want_dir != DIR_ANY && {1'b0, ep_shadow[i].dir} != req.want_dir)
				continue;
			if (req.want_num != NUM_ANY && {1'b0, ep_shadow[i].num} != req.want_num)
				continue;
			if (req.want_type != TYPE_ANY && {1'b0, ep_shadow[i].xfer} != req.want_type)
				continue;
			if (skip == 8'd0 && filtered) begin
				res.found = 1'b1;
				res.found_slot = i[4:0];
				return res;
			end
			skip = skip - 8'd1;
		end
		// control endpoint: no filter took effect (or nothing of this interface
		// was seen) and the skip count ran out exactly
		if (shadow_ctrl && !(seen && filtered) && skip == 8'd0) begin
			res.found = 1'b1;
			res.is_control = 1'b1;
		end
		return res;
	endfunction

	// unused fields of a transaction carry random noise
	function automatic ep_item_t mk_write(logic [4:0] slot, logic present, logic [7:0] iface,
			logic dir, logic [3:0] num, logic [1:0] xfer);
		ep_item_t it;
		logic [63:0] noise;
		noise = {$urandom(), $urandom()};
		it = noise[$bits(ep_item_t)-1:0];
		it.func = FUNC_WRITE;
		it.slot = slot;
		it.entry.present = present;
		it.entry.iface = iface;
		it.entry.dir = dir;
		it.entry.num = num;
		it.entry.xfer = xfer;
		return it;
	endfunction

	function automatic ep_item_t mk_lookup(logic [7:0] iface, logic [1:0] dir,
			logic [4:0] num, logic [2:0] xfer, logic [7:0] nth);
		ep_item_t it;
		logic [63:0] noise;
		noise = {$urandom(), $urandom()};
		it = noise[$bits(ep_item_t)-1:0];
		it.func = FUNC_LOOKUP;
		it.want_iface = iface;
		it.want_dir = dir;
		it.want_num = num;
		it.want_type = xfer;
		it.want_nth = nth;
		return it;
	endfunction

	// idle length: mostly short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(99, 0);
		if (r < 75)
			return $urandom_range(3, 1);
		if (r < 95)
			return $urandom_range(10, 4);
		return $urandom_range(80, 20);
	endfunction

	task automatic report_mismatch(input string what);
		n_mismatches++;
		if (n_mismatches <= MAX_REPORTS)
			$display("MISMATCH at %0t: %s", $time, what);
	endtask

	// ---------------------------------------------------------------------
	// Item driver: offers queued transactions, predicts at acceptance.
	// valid gets exactly one nonblocking update per edge.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive_items
		bit offer;
		if (!arst_n) begin
			item_ch.valid <= 1'b0;
			src_gap = 0;
		end else begin
			offer = item_ch.valid;
			if (item_ch.valid && item_ch.ready) begin
				if (cur_item.func == FUNC_WRITE) begin
					ep_shadow[cur_item.slot] = cur_item.entry;
					n_writes++;
				end else begin
					expected_matches.push_back(nth_match(cur_item));
					n_lookups++;
				end
				offer = 1'b0;
			end
			if (!offer) begin
				if (src_gap != 0) begin
					src_gap--;
				end else if (pending_items.size() != 0) begin
					cur_item = pending_items.pop_front();
					offer = 1'b1;
					item_ch.func          <= cur_item.func;
					item_ch.slot          <= cur_item.slot;
					item_ch.entry_present <= cur_item.entry.present;
					item_ch.entry_iface   <= cur_item.entry.iface;
					item_ch.entry_dir     <= cur_item.entry.dir;
					item_ch.entry_num     <= cur_item.entry.num;
					item_ch.entry_type    <= cur_item.entry.xfer;
					item_ch.want_iface    <= cur_item.want_iface;
					item_ch.want_dir      <= cur_item.want_dir;
					item_ch.want_num      <= cur_item.want_num;
					item_ch.want_type     <= cur_item.want_type;
					item_ch.want_nth      <= cur_item.want_nth;
					// gap before the next offer, taken after this one is accepted
					src_gap = (src_idle_on && $urandom_range(1, 0) != 0) ? idle_len() : 0;
				end
			end
			item_ch.valid <= offer;
		end
	end

	// long receiver hold-off, counted here so the sender keeps going meanwhile
	always @(posedge clk or negedge arst_n) begin : hold_counter
		if (!arst_n)
			hold_left <= 0;
		else if (hold_kick && hold_left == 0)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	// ---------------------------------------------------------------------
	// Result monitor: each accepted result transaction against the oldest
	// expectation, field by field.
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : collect_results
		ep_match_t want;
		bit rdy;
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
			sink_gap = 0;
		end else begin
			if (res_ch.valid && res_ch.ready) begin
				if (expected_matches.size() == 0) begin
					report_mismatch($sformatf("result with no lookup outstanding: %b %b %0d",
						res_ch.found, res_ch.is_control, res_ch.found_slot));
				end else begin
					want = expected_matches.pop_front();
					if (res_ch.found !== want.found)
						report_mismatch($sformatf("found: got %b, want %b",
							res_ch.found, want.found));
					if (res_ch.is_control !== want.is_control)
						report_mismatch($sformatf("is_control: got %b, want %b",
							res_ch.is_control, want.is_control));
					if (res_ch.found_slot !== want.found_slot)
						report_mismatch($sformatf("found_slot: got %0d, want %0d",
							res_ch.found_slot, want.found_slot));
					if (!want.found)
						n_misses++;
					else if (want.is_control)
						n_ctrl++;
					else
						n_hits++;
				end
			end
			rdy = 1'b0;
			if (sink_gap != 0)
				sink_gap--;
			else if (sink_idle_on && $urandom_range(99, 0) < 15)
				sink_gap = idle_len();
			else
				rdy = (hold_left == 0);
			res_ch.ready <= rdy;
		end
	end

	// watchdog
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_matches.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	// register write transaction on the config channel
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_EP_COUNT)
			shadow_ep_count = val[EP_COUNT_W-1:0];
		else if (idx == REG_CTRL_PRESENT)
			shadow_ctrl = val[0];
		n_cfg_writes++;
		cfg_ch.valid <= 1'b0;
	endtask

	// wait until the sender is empty and all results are in, then wait
	// LOOKUP_CYCLES more before registers may change
	task automatic drain_and_wait();
		do @(negedge clk);
		while (pending_items.size() != 0 || item_ch.valid || expected_matches.size() != 0);
		repeat (LOOKUP_CYCLES) @(posedge clk);
	endtask

	// One random phase: new register settings, a fresh table fill, then a
	// mix of writes and lookups aimed mostly at the interfaces in the table.
	task automatic run_phase(input logic [EP_COUNT_W-1:0] ep_count_val, input logic ctrl_val,
			input int n_items, input bit src_idle, input bit sink_idle, input bit hold);
		logic [7:0] pool [3];
		logic [7:0] wif;
		logic [1:0] wdir;
		logic [4:0] wnum;
		logic [2:0] wtype;
		logic [7:0] wnth;
		logic [3:0] enum_val;
		int pushed;
		int r;
		drain_and_wait();
		write_reg(REG_EP_COUNT, {2'($urandom), ep_count_val});
		write_reg(REG_CTRL_PRESENT, {7'($urandom), ctrl_val});
		write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), 8'($urandom));
		foreach (pool[k])
			pool[k] = 8'($urandom);
		@(negedge clk);
		src_idle_on = src_idle;
		sink_idle_on = sink_idle;
		hold_kick = hold;
		pushed = 0;
		// table fill, with most slots present
		for (int s = 0; s < EP_DEPTH; s++) begin
			if ($urandom_range(3, 0) == 0)
				continue;
			wif = ($urandom_range(99, 0) < 85) ? pool[$urandom_range(2, 0)] : 8'($urandom);
			enum_val = ($urandom_range(9, 0) < 7) ? 4'($urandom_range(3, 0)) : 4'($urandom);
			pending_items.push_back(mk_write(s[4:0], $urandom_range(9, 0) != 0, wif,
				1'($urandom), enum_val, 2'($urandom)));
			pushed++;
		end
		while (pushed < n_items) begin
			wif = ($urandom_range(99, 0) < 85) ? pool[$urandom_range(2, 0)] : 8'($urandom);
			if ($urandom_range(99, 0) < 15) begin
				enum_val = ($urandom_range(9, 0) < 7) ? 4'($urandom_range(3, 0)) : 4'($urandom);
				pending_items.push_back(mk_write(5'($urandom), $urandom_range(9, 0) != 0, wif,
					1'($urandom), enum_val, 2'($urandom)));
			end else begin
				r = $urandom_range(9, 0);
				wdir = (r < 6) ? 2'($urandom_range(1, 0)) : (r < 9) ? DIR_ANY : DIR_INVALID;
				r = $urandom_range(9, 0);
				wnum = (r < 5) ? 5'($urandom_range(3, 0)) : (r < 7) ? 5'($urandom_range(15, 0)) :
					(r < 9) ? NUM_ANY : 5'($urandom_range(31, NUM_INVALID));
				r = $urandom_range(9, 0);
				wtype = (r < 6) ? 3'($urandom_range(3, 0)) : (r < 9) ? TYPE_ANY :
					3'($urandom_range(7, TYPE_INVALID));
				// all wildcards is the only way to the control endpoint on a busy table
				if ($urandom_range(9, 0) == 0) begin
					wdir = DIR_ANY;
					wnum = NUM_ANY;
					wtype = TYPE_ANY;
				end
				r = $urandom_range(9, 0);
				wnth = (r < 7) ? 8'($urandom_range(3, 0)) : (r < 9) ? 8'($urandom) :
					8'(255 - $urandom_range(1, 0));
				pending_items.push_back(mk_lookup(wif, wdir, wnum, wtype, wnth));
			end
			pushed++;
		end
		@(negedge clk);
		hold_kick = 1'b0;
	endtask

	initial begin : stimulus
		foreach (ep_shadow[i])
			ep_shadow[i] = '0;
		shadow_ep_count = '0;
		shadow_ctrl = 1'b0;
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		hold_kick = 1'b0;
		n_mismatches = 0;
		cycle_count = 0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		item_ch.valid = 1'b0;
		item_ch.func = FUNC_WRITE;
		item_ch.slot = '0;
		item_ch.entry_present = 1'b0;
		item_ch.entry_iface = '0;
		item_ch.entry_dir = 1'b0;
		item_ch.entry_num = '0;
		item_ch.entry_type = '0;
		item_ch.want_iface = '0;
		item_ch.want_dir = '0;
		item_ch.want_num = '0;
		item_ch.want_type = '0;
		item_ch.want_nth = '0;
		res_ch.ready = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// straight out of reset: nothing searched, no control endpoint
		@(negedge clk);
		pending_items.push_back(mk_lookup(8'h00, DIR_ANY, NUM_ANY, TYPE_ANY, 8'd0));
		drain_and_wait();
		write_reg(REG_EP_COUNT, 8'd32);
		write_reg(REG_CTRL_PRESENT, 8'd1);
		// spare index with data that would wipe ep_count if it aliased
		write_reg(REG_SPARE_LO, 8'h00);

		// directed: field extremes, every filter kind, control endpoint cases
		@(negedge clk);
		pending_items.push_back(mk_write(5'd0, 1'b1, 8'h00, DIR_OUT, 4'd0, XFER_CTRL));
		pending_items.push_back(mk_write(5'd31, 1'b1, 8'hFF, DIR_IN, 4'd15, XFER_INTR));
		pending_items.push_back(mk_write(5'd5, 1'b1, 8'hFF, DIR_IN, 4'd15, XFER_INTR));
		// absent entry and an entry of another interface must both be skipped
		pending_items.push_back(mk_write(5'd7, 1'b0, 8'hFF, DIR_IN, 4'd15, XFER_INTR));
		pending_items.push_back(mk_write(5'd9, 1'b1, 8'hFE, DIR_IN, 4'd15, XFER_INTR));
		pending_items.push_back(mk_write(5'd12, 1'b1, 8'hFF, DIR_OUT, 4'd2, XFER_BULK));
		pending_items.push_back(mk_lookup(8'hFF, DIR_IN, 5'd15, XFER_INTR, 8'd0));
		pending_items.push_back(mk_lookup(8'hFF, DIR_IN, 5'd15, XFER_INTR, 8'd1));
		pending_items.push_back(mk_lookup(8'hFF, DIR_IN, 5'd15, XFER_INTR, 8'd2));
		// all wildcards: counter wraps past zero, then lands on zero exactly
		pending_items.push_back(mk_lookup(8'hFF, DIR_ANY, NUM_ANY, TYPE_ANY, 8'd0));
		pending_items.push_back(mk_lookup(8'hFF, DIR_ANY, NUM_ANY, TYPE_ANY, 8'd3));
		// out-of-range filter codes are real filters that match nothing
		pending_items.push_back(mk_lookup(8'hFF, DIR_INVALID, NUM_ANY, TYPE_ANY, 8'd0));
		pending_items.push_back(mk_lookup(8'hFF, DIR_ANY, NUM_INVALID, TYPE_ANY, 8'd0));
		pending_items.push_back(mk_lookup(8'hFF, DIR_ANY, NUM_ANY, TYPE_INVALID, 8'd0));
		pending_items.push_back(mk_lookup(8'hFF, DIR_ANY, NUM_ANY, 3'(XFER_BULK), 8'd0));
		pending_items.push_back(mk_lookup(8'h00, 2'(DIR_OUT), NUM_ANY, TYPE_ANY, 8'd0));
		pending_items.push_back(mk_lookup(8'h00, DIR_ANY, 5'd0, 3'(XFER_CTRL), 8'd0));
		// interface not in the table: control endpoint unless a skip remains
		pending_items.push_back(mk_lookup(8'h63, 2'(DIR_IN), 5'd3, 3'(XFER_ISO), 8'd0));
		pending_items.push_back(mk_lookup(8'h63, 2'(DIR_IN), 5'd3, 3'(XFER_ISO), 8'd255));

		// random phases; the second one holds results off for a long stretch
		run_phase(6'd32, 1'b1, 250, 1'b1, 1'b1, 1'b0);
		run_phase(6'd20, 1'b0, 200, 1'b1, 1'b1, 1'b1);
		run_phase(6'd0, 1'b1, 100, 1'b1, 1'b1, 1'b0);
		// ep_count beyond the table depth saturates; no idling on either side
		run_phase(6'd63, 1'b1, 250, 1'b0, 1'b0, 1'b0);
		run_phase(6'd1, 1'b0, 100, 1'b1, 1'b1, 1'b0);
		run_phase(6'd31, 1'b1, 250, 1'b1, 1'b0, 1'b0);
		run_phase(6'($urandom), 1'($urandom), 250, 1'b0, 1'b1, 1'b0);
		run_phase(6'd32, 1'b0, 250, 1'b1, 1'b1, 1'b0);
		drain_and_wait();

		$display("covered %0d table writes, %0d lookups and %0d register writes",
			n_writes, n_lookups, n_cfg_writes);
		$display("lookup outcomes: %0d table hits, %0d control, %0d not found; %0d mismatches",
			n_hits, n_ctrl, n_misses, n_mismatches);
		if (n_mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
